FILE: sv/cpf_pkg.sv
// Shared types and constants for the checksummed packet FIFO.
package cpf_pkg;

    localparam int SLOTS   = 16;
    localparam int MAX_LEN = 4096;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int ADDR_W  = SLOT_W + IDX_W;
    localparam int LEN_W   = 13;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int INC_W   = $clog2(MAX_LEN + 1);

    localparam logic [1:0] CMD_RECV  = 2'd0;
    localparam logic [1:0] CMD_FETCH = 2'd1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD     = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_NOPKT   = 3'd3,
        ST_SHUT    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] expected_checksum;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       out_byte;
        logic             out_last;
        logic [LEN_W-1:0] length;
        logic [7:0]       checksum;
        logic [15:0]      bad_count;
    } out_item_t;

    // One queued operation for the back end: a buffer write or read plus
    // the result it produces, if any.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              emit;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wr_data;
        out_item_t         res;
    } op_t;

endpackage

FILE: sv/checksummed_packet_fifo_unit.sv
// Top level of the checksummed packet FIFO.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  item in  | start, busy (start&!busy) | item   (in_item_t)
//  result   | done, one-cycle strobe | result (out_item_t)
//
// One item is accepted per cycle; busy only rises if the op queue fills,
// which cannot happen because the back end drains one op every cycle.
// A result passes the queue entry, then the back end's result register and
// buffer read register. Receive bytes that are not final give no result.
// Reset clears all bookkeeping; the packet buffer and slot metadata are
// not cleared and are only read after being written.
// The receiver cannot stall: results are never held.
module checksummed_packet_fifo_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cpf_pkg::in_item_t  item,
    output logic               done,
    output cpf_pkg::out_item_t result
);
    import cpf_pkg::*;

    logic accept;
    logic push;
    op_t  push_op;
    op_t  pop_op;
    logic q_full;
    logic q_empty;

    assign accept = start && !busy;
    assign busy   = q_full;

    // front: classify item, update slot state, build op
    cpf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .op     (push_op)
    );

    // decouples bookkeeping from the buffer access
    cpf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (!q_empty),
        .full    (q_full),
        .empty   (q_empty),
        .pop_op  (pop_op)
    );

    // back: byte buffer write/read, result register
    cpf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (!q_empty),
        .op     (pop_op),
        .done   (done),
        .result (result)
    );

endmodule

FILE: sv/cpf_front.sv
// Front end: accepts items, keeps packet and slot bookkeeping, issues operations.
module cpf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  cpf_pkg::in_item_t item,
    output logic            push,
    output cpf_pkg::op_t    op
);
    import cpf_pkg::*;

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic [INC_W-1:0]  inc_reg, inc_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    logic              drop_reg, drop_next;
    logic [15:0]       bad_reg, bad_next;
    logic              halted_reg, halted_next;

    logic [LEN_W-1:0]  slot_len_reg [SLOTS];
    logic [7:0]        slot_chk_reg [SLOTS];

    logic              meta_we;
    logic              drop_eff;
    logic              keep;
    logic [7:0]        sum_new;
    logic [INC_W-1:0]  inc_new;
    logic [LEN_W-1:0]  head_len;
    logic              fin;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    assign head_len = slot_len_reg[head_reg];
    assign drop_eff = (inc_reg == '0) ? (count_reg >= CNT_W'(SLOTS)) : drop_reg;
    assign keep     = inc_reg < INC_W'(MAX_LEN);
    assign sum_new  = keep ? sum_reg + item.data_byte : sum_reg;
    assign inc_new  = inc_reg + INC_W'(keep);
    assign fin      = (LEN_W'(fidx_reg) + 1'b1) >= head_len;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        inc_next    = inc_reg;
        fidx_next   = fidx_reg;
        drop_next   = drop_reg;
        bad_next    = bad_reg;
        halted_next = halted_reg;
        meta_we     = 1'b0;
        push        = 1'b0;
        op          = '0;
        op.res.bad_count = bad_reg;

        if (accept)
        begin
            push = 1'b1;
            if (halted_reg || (item.command != CMD_RECV && item.command != CMD_FETCH))
            begin
                halted_next   = 1'b1;
                op.emit       = 1'b1;
                op.res.status = ST_SHUT;
            end
            else if (item.command == CMD_RECV)
            begin
                op.wr_en   = keep && !drop_eff;
                op.addr    = {tail_reg, inc_reg[IDX_W-1:0]};
                op.wr_data = item.data_byte;
                if (item.last_byte)
                begin
                    op.emit         = 1'b1;
                    op.res.length   = LEN_W'(inc_new);
                    op.res.checksum = sum_new;
                    if (drop_eff)
                    begin
                        op.res.status = ST_NOSPACE;
                    end
                    else if (sum_new != item.expected_checksum)
                    begin
                        op.res.status = ST_BAD;
                        if (bad_reg != 16'hFFFF)
                        begin
                            bad_next = bad_reg + 1'b1;
                        end
                        op.res.bad_count = bad_next;
                    end
                    else
                    begin
                        op.res.status = ST_OK;
                        meta_we       = 1'b1;
                        tail_next     = next_slot(tail_reg);
                        count_next    = count_reg + 1'b1;
                    end
                    sum_next  = '0;
                    inc_next  = '0;
                    drop_next = 1'b0;
                end
                else
                begin
                    sum_next  = sum_new;
                    inc_next  = inc_new;
                    drop_next = drop_eff;
                end
            end
            else
            begin
                op.emit = 1'b1;
                if (count_reg == '0)
                begin
                    op.res.status = ST_NOPKT;
                end
                else
                begin
                    op.rd_en        = 1'b1;
                    op.addr         = {head_reg, fidx_reg};
                    op.res.status   = ST_OK;
                    op.res.out_last = fin;
                    op.res.length   = head_len;
                    op.res.checksum = slot_chk_reg[head_reg];
                    if (fin)
                    begin
                        fidx_next  = '0;
                        head_next  = next_slot(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            inc_reg    <= '0;
            fidx_reg   <= '0;
            drop_reg   <= 1'b0;
            bad_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            inc_reg    <= inc_next;
            fidx_reg   <= fidx_next;
            drop_reg   <= drop_next;
            bad_reg    <= bad_next;
            halted_reg <= halted_next;
        end
    end

    // slot metadata, no reset
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            slot_len_reg[tail_reg] <= op.res.length;
            slot_chk_reg[tail_reg] <= op.res.checksum;
        end
    end

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("shutdown flag cleared");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("stored packet count out of range");
    a_wr_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        (push && op.wr_en && count_reg != '0) |-> (op.addr[ADDR_W-1:IDX_W] != head_reg))
        else $error("receive write into a stored slot");
`endif

endmodule

FILE: sv/cpf_queue.sv
// Two-entry operation queue between front and back end.
module cpf_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cpf_pkg::op_t push_op,
    input  logic         pop,
    output logic         full,
    output logic         empty,
    output cpf_pkg::op_t pop_op
);
    import cpf_pkg::*;

    op_t        ent_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wp_reg] <= push_op;
        end
    end

endmodule

FILE: sv/cpf_back.sv
// Back end: packet byte buffer and registered result stage.
module cpf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  cpf_pkg::op_t       op,
    output logic               done,
    output cpf_pkg::out_item_t result
);
    import cpf_pkg::*;

    logic [7:0] pkt_mem [2**ADDR_W];
    logic [7:0] rd_data_reg;
    logic       rd_reg, rd_next;
    logic       done_reg, done_next;
    out_item_t  res_reg;

    assign rd_next   = valid && op.rd_en;
    assign done_next = valid && op.emit;

    always_ff @(posedge clk)
    begin
        if (valid && op.wr_en)
        begin
            pkt_mem[op.addr] <= op.wr_data;
        end
        if (valid && op.rd_en)
        begin
            rd_data_reg <= pkt_mem[op.addr];
        end
        res_reg <= op.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rd_reg   <= rd_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        result          = res_reg;
        result.out_byte = rd_reg ? rd_data_reg : 8'h00;
    end

    assign done = done_reg;

endmodule
